/* design/tfmf_pkg.sv */
// Shared constants and controller/datapath interface types for the
// thermocouple frame median filter. No dependencies.
package tfmf_pkg;

  localparam int unsigned SAMPLES = 21;
  localparam int unsigned IDX_W   = $clog2(SAMPLES);
  localparam int unsigned CNT_W   = $clog2(SAMPLES + 1);
  localparam int unsigned MID     = (SAMPLES - 1) / 2;

  localparam int unsigned FRAME_W = 32;
  localparam int unsigned TC_W    = 14;
  localparam int unsigned INT_W   = 12;
  localparam int unsigned FAULT_W = 3;
  localparam int unsigned ERR_W   = 16;

  localparam logic [ERR_W-1:0]   ERR_LIMIT_RESET = 16'd20000;
  localparam logic [ERR_W-1:0]   ERR_MAX         = 16'hFFFF;
  localparam logic [FAULT_W-1:0] FAULT_OPEN      = 3'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic err_inc;
    logic restart;
    logic start_ins;
    logic shift;
    logic place;
    logic med_rd;
    logic take_median;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fault;
    logic limit_hit;
    logic shift_go;
    logic full;
    logic out_free;
  } sts_t;

endpackage

/* design/tfmf_ctrl.sv */
// Controller for the thermocouple frame median filter: sequences decode,
// insertion sort, median read and result hand-off. Uses tfmf_pkg.
module tfmf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tfmf_pkg::sts_t sts_i,
  output tfmf_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_MEDRD  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.fault) begin
          cmd_o.err_inc = 1'b1;
          state_d       = ST_DONE;
        end else if (sts_i.limit_hit) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.start_ins = 1'b1;
          state_d         = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // move larger entries up one slot until the new sample fits
        if (sts_i.shift_go) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.full) begin
          cmd_o.med_rd = 1'b1;
          state_d      = ST_MEDRD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MEDRD: begin
        cmd_o.take_median = 1'b1;
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/tfmf_datapath.sv */
// Datapath for the thermocouple frame median filter: field decode, counters,
// sorted sample memory and output register. Uses tfmf_pkg.
module tfmf_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [tfmf_pkg::FRAME_W-1:0]         frame_i,
  input  logic                                 cfg_valid_i,
  input  logic [tfmf_pkg::ERR_W-1:0]           cfg_error_limit_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [tfmf_pkg::TC_W-1:0]     median_temp_o,
  output logic                                 median_valid_o,
  output logic signed [tfmf_pkg::INT_W-1:0]    internal_temp_o,
  output logic [tfmf_pkg::FAULT_W-1:0]         fault_code_o,
  output logic                                 led_on_o,
  output logic                                 restarted_o,
  input  tfmf_pkg::cmd_t                       cmd_i,
  output tfmf_pkg::sts_t                       sts_o
);

  logic [tfmf_pkg::ERR_W-1:0]          err_limit_q;
  logic [tfmf_pkg::ERR_W-1:0]          err_cnt_q;
  logic [tfmf_pkg::CNT_W-1:0]          cnt_q;
  logic [tfmf_pkg::IDX_W-1:0]          k_q;

  logic signed [tfmf_pkg::TC_W-1:0]    tc_q;
  logic signed [tfmf_pkg::INT_W-1:0]   int_q;
  logic [tfmf_pkg::FAULT_W-1:0]        fault_q;
  logic signed [tfmf_pkg::TC_W-1:0]    median_q;
  logic                                valid_q;
  logic                                restarted_q;

  logic signed [tfmf_pkg::TC_W-1:0]    mem [tfmf_pkg::SAMPLES];
  logic signed [tfmf_pkg::TC_W-1:0]    rd_data_q;
  logic [tfmf_pkg::IDX_W-1:0]          rd_addr;
  logic                                rd_en;
  logic [tfmf_pkg::IDX_W-1:0]          wr_addr;
  logic signed [tfmf_pkg::TC_W-1:0]    wr_data;
  logic                                wr_en;

  logic                                out_valid_q;

  // read port: previous slot at start, the slot below next during shifts, the median slot on med_rd
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.start_ins) begin
      rd_en   = 1'b1;
      rd_addr = tfmf_pkg::IDX_W'(cnt_q - tfmf_pkg::CNT_W'(1));
    end else if (cmd_i.shift) begin
      rd_en   = 1'b1;
      rd_addr = k_q - tfmf_pkg::IDX_W'(2);
    end else if (cmd_i.med_rd) begin
      rd_en   = 1'b1;
      rd_addr = tfmf_pkg::IDX_W'(tfmf_pkg::MID);
    end
  end

  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_addr = k_q;
  assign wr_data = cmd_i.shift ? rd_data_q : tc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign sts_o.fault     = (fault_q != '0);
  assign sts_o.limit_hit = (err_cnt_q >= err_limit_q);
  assign sts_o.shift_go  = (k_q != '0) && (rd_data_q > tc_q);
  assign sts_o.full      = (cnt_q == tfmf_pkg::CNT_W'(tfmf_pkg::SAMPLES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // frame fields and per-item result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tc_q        <= frame_i[31:18];
      int_q       <= frame_i[15:4];
      fault_q     <= frame_i[2:0];
      median_q    <= '0;
      valid_q     <= 1'b0;
      restarted_q <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        restarted_q <= 1'b1;
      end
      if (cmd_i.take_median) begin
        median_q <= rd_data_q;
        valid_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_ins) begin
      k_q <= tfmf_pkg::IDX_W'(cnt_q);
    end else if (cmd_i.shift) begin
      k_q <= k_q - tfmf_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_limit_q <= tfmf_pkg::ERR_LIMIT_RESET;
      err_cnt_q   <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        err_limit_q <= cfg_error_limit_i;
      end
      if (cmd_i.err_inc && (err_cnt_q != tfmf_pkg::ERR_MAX)) begin
        err_cnt_q <= err_cnt_q + tfmf_pkg::ERR_W'(1);
      end
      if (cmd_i.place) begin
        cnt_q <= cnt_q + tfmf_pkg::CNT_W'(1);
      end
      // drop the collection and clear the error count on restart or after a median
      if (cmd_i.restart || cmd_i.take_median) begin
        cnt_q     <= '0;
        err_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      median_temp_o   <= median_q;
      median_valid_o  <= valid_q;
      internal_temp_o <= int_q;
      fault_code_o    <= fault_q;
      led_on_o        <= (fault_q == tfmf_pkg::FAULT_OPEN);
      restarted_o     <= restarted_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/thermocouple_frame_median_filter.sv */
// Top level of the thermocouple frame median filter: joins the controller
// and the datapath. Uses tfmf_pkg, tfmf_ctrl and tfmf_datapath.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_error_limit_i
//   in       in         in_valid_i / in_ready_o   frame_i
//   out      out        out_valid_o / out_ready_i median_temp_o .. restarted_o
//
// A faulty or restarting frame goes from accept through the decide and done
// states to the result register; a good frame also passes the shift state,
// where the insertion sort moves up to SAMPLES-1 stored samples, the check
// state and, when it completes a collection, the median read state.
// One item is in work at a time. Reset clears the counters and sets the
// error limit to 20000; the sample memory needs no clearing. A stalled output
// holds the finished item and keeps the next one from leaving the work stage.
module thermocouple_frame_median_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tfmf_pkg::ERR_W-1:0]           cfg_error_limit_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tfmf_pkg::FRAME_W-1:0]         frame_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [tfmf_pkg::TC_W-1:0]     median_temp_o,
  output logic                                 median_valid_o,
  output logic signed [tfmf_pkg::INT_W-1:0]    internal_temp_o,
  output logic [tfmf_pkg::FAULT_W-1:0]         fault_code_o,
  output logic                                 led_on_o,
  output logic                                 restarted_o
);

  tfmf_pkg::cmd_t cmd;
  tfmf_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tfmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tfmf_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_i           (frame_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_error_limit_i (cfg_error_limit_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .median_temp_o     (median_temp_o),
    .median_valid_o    (median_valid_o),
    .internal_temp_o   (internal_temp_o),
    .fault_code_o      (fault_code_o),
    .led_on_o          (led_on_o),
    .restarted_o       (restarted_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
